FILE: hw/rtl/serial_phase_command_parser_core_assert.svh
// assertion macros used by the checker file spcp_checker.sv
`ifndef SERIAL_PHASE_COMMAND_PARSER_CORE_ASSERT_SVH
`define SERIAL_PHASE_COMMAND_PARSER_CORE_ASSERT_SVH

// clocked assertion, held off while reset is asserted
`define SPCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spcp assertion failed");

// implication from a condition to a consequence in the same cycle
`define SPCP_ASSERT_IMP(label, cond, cons) \
  `SPCP_ASSERT(label, (cond) |-> (cons))

`endif

FILE: hw/rtl/spcp_pkg.sv
// types, constants and character tables of the serial phase command parser
package spcp_pkg;

  localparam int unsigned LINE_CAPACITY = 32;

  localparam int unsigned PREFIX_LEN  = 10;
  localparam int unsigned RESET_LEN   = 5;
  localparam int unsigned NUM_W       = 14;
  localparam int unsigned PHASE_MAX   = 180;
  localparam int unsigned DIGIT_LIMIT = 1000;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_IMM_RESET  = 3'd1,
    EV_RESET_LINE = 3'd2,
    EV_PHASE_OK   = 3'd3,
    EV_SYNTAX     = 3'd4,
    EV_RANGE      = 3'd5,
    EV_UNKNOWN    = 3'd6
  } event_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } spcp_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] phase_value;
  } spcp_out_t;

  // "SET PHASE "
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h53;
      4'd1:    ch = 8'h45;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h20;
      4'd4:    ch = 8'h50;
      4'd5:    ch = 8'h48;
      4'd6:    ch = 8'h41;
      4'd7:    ch = 8'h53;
      4'd8:    ch = 8'h45;
      4'd9:    ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "RESET"
  function automatic logic [7:0] reset_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h52;
      3'd1:    ch = 8'h45;
      3'd2:    ch = 8'h53;
      3'd3:    ch = 8'h45;
      3'd4:    ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/spcp_engine.sv
// streaming line parser: matcher, line state and end-of-line classification
module spcp_engine #(
  parameter int unsigned LineCapacity = spcp_pkg::LINE_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  spcp_pkg::spcp_in_t  item_i,
  output spcp_pkg::spcp_out_t res_o
);
  import spcp_pkg::*;

  localparam int unsigned LenW = $clog2(LineCapacity);

  logic [LenW-1:0]  len_q, len_d;
  logic [2:0]       match_q, match_d;
  logic [3:0]       prefix_q, prefix_d;
  logic             prefix_fail_q, prefix_fail_d;
  logic             rst_fail_q, rst_fail_d;
  logic             seen_q, seen_d;
  logic             invalid_q, invalid_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic             last_ok_q, last_ok_d;

  logic [7:0]       ch;
  logic [2:0]       match_next;
  logic             is_eol;
  logic             is_digit;
  logic [3:0]       digit;
  event_e           cls_ev;
  logic [7:0]       cls_phase;
  event_e           ev;
  logic [7:0]       phase;

  assign ch       = item_i.byte_value;
  assign is_eol   = (ch == CHAR_CR) || (ch == CHAR_LF);
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign digit    = ch[3:0];

  always_comb begin
    if ((match_q < 3'(RESET_LEN)) && (ch == reset_char(match_q))) begin
      match_next = match_q + 3'd1;
    end else if (ch == CHAR_R) begin
      match_next = 3'd1;
    end else begin
      match_next = 3'd0;
    end
  end

  // classification of the line held in the registers
  always_comb begin
    cls_phase = 8'd0;
    if (!rst_fail_q && (len_q == LenW'(RESET_LEN))) begin
      cls_ev = EV_RESET_LINE;
    end else if (prefix_q < 4'(PREFIX_LEN - 1)) begin
      cls_ev = EV_UNKNOWN;
    end else if ((prefix_q != 4'(PREFIX_LEN)) || !seen_q || invalid_q) begin
      cls_ev = EV_SYNTAX;
    end else if ((num_q > NUM_W'(PHASE_MAX)) || !last_ok_q) begin
      cls_ev = EV_RANGE;
    end else begin
      cls_ev    = EV_PHASE_OK;
      cls_phase = num_q[7:0];
    end
  end

  always_comb begin
    len_d         = len_q;
    match_d       = match_q;
    prefix_d      = prefix_q;
    prefix_fail_d = prefix_fail_q;
    rst_fail_d    = rst_fail_q;
    seen_d        = seen_q;
    invalid_d     = invalid_q;
    num_d         = num_q;
    last_ok_d     = last_ok_q;
    ev            = EV_NONE;
    phase         = 8'd0;

    if (step_i) begin
      if (item_i.kind) begin
        match_d = 3'd0;
        len_d   = '0;
      end else if (match_next >= 3'(RESET_LEN)) begin
        ev      = EV_IMM_RESET;
        match_d = 3'd0;
        len_d   = '0;
      end else if (is_eol) begin
        match_d = match_next;
        if (len_q != '0) begin
          ev    = cls_ev;
          phase = cls_phase;
          len_d = '0;
          if (cls_ev == EV_RESET_LINE) begin
            match_d = 3'd0;
          end
        end
      end else if (len_q < LenW'(LineCapacity - 1)) begin
        match_d = match_next;
        len_d   = len_q + LenW'(1);
        if ((len_q >= LenW'(RESET_LEN)) || (ch != reset_char(len_q[2:0]))) begin
          rst_fail_d = 1'b1;
        end
        if (len_q < LenW'(PREFIX_LEN)) begin
          if (!prefix_fail_q) begin
            if (ch == prefix_char(len_q[3:0])) begin
              prefix_d = len_q[3:0] + 4'd1;
            end else begin
              prefix_fail_d = 1'b1;
            end
          end
        end else if (is_digit) begin
          if (!invalid_q) begin
            if (num_q > NUM_W'(DIGIT_LIMIT)) begin
              invalid_d = 1'b1;
            end else begin
              num_d     = num_q * NUM_W'(10) + NUM_W'(digit);
              seen_d    = 1'b1;
              // 10 is a multiple of 5, so only the last digit decides
              last_ok_d = (digit == 4'd0) || (digit == 4'd5);
            end
          end
        end else begin
          invalid_d = 1'b1;
        end
      end else begin
        // overflowing character drops the line
        match_d = match_next;
        len_d   = '0;
      end

      // any line clear also resets the per-line trackers
      if (len_d == '0) begin
        prefix_d      = 4'd0;
        prefix_fail_d = 1'b0;
        rst_fail_d    = 1'b0;
        seen_d        = 1'b0;
        invalid_d     = 1'b0;
        num_d         = '0;
        last_ok_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q         <= '0;
      match_q       <= 3'd0;
      prefix_q      <= 4'd0;
      prefix_fail_q <= 1'b0;
      rst_fail_q    <= 1'b0;
      seen_q        <= 1'b0;
      invalid_q     <= 1'b0;
      num_q         <= '0;
      last_ok_q     <= 1'b0;
    end else begin
      len_q         <= len_d;
      match_q       <= match_d;
      prefix_q      <= prefix_d;
      prefix_fail_q <= prefix_fail_d;
      rst_fail_q    <= rst_fail_d;
      seen_q        <= seen_d;
      invalid_q     <= invalid_d;
      num_q         <= num_d;
      last_ok_q     <= last_ok_d;
    end
  end

  assign res_o.event_res   = ev;
  assign res_o.phase_value = phase;

endmodule

FILE: hw/rtl/spcp_out_stage.sv
// result register with valid flag, frees itself when the item is taken
module spcp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  spcp_pkg::spcp_out_t data_i,
  input  logic                ready_i,
  output logic                valid_o,
  output spcp_pkg::spcp_out_t data_o,
  output logic                free_o
);
  import spcp_pkg::*;

  logic      valid_q, valid_d;
  spcp_out_t data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/serial_phase_command_parser_core.sv
// an accepted item is held in the input register, and its result is then registered in the result register
// throughput: one item per cycle while the output is not stalled; input register -> parser logic -> result register
// stalls on the output back up through the input register only, never drop an item
// reset (rst_ni low, asynchronous) clears the matcher, the line state and both valids
module serial_phase_command_parser_core #(
  parameter int unsigned LineCapacity = spcp_pkg::LINE_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spcp_pkg::spcp_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spcp_pkg::spcp_out_t out_item_o
);
  import spcp_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  spcp_in_t  s1_item_q;
  logic      out_free;
  logic      step;
  logic      in_fire;
  spcp_out_t res;

  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  spcp_engine #(
    .LineCapacity(LineCapacity)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(s1_item_q),
    .res_o (res)
  );

  spcp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .data_i (res),
    .ready_i(out_ready_i),
    .valid_o(out_valid_o),
    .data_o (out_item_o),
    .free_o (out_free)
  );

endmodule

FILE: hw/rtl/spcp_checker.sv
// port-level checks of the parser core, bound to the top level
`include "serial_phase_command_parser_core_assert.svh"

module spcp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input spcp_pkg::spcp_out_t out_item_o
);
  import spcp_pkg::*;

  `SPCP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
  `SPCP_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o)
  `SPCP_ASSERT_IMP(a_phase_only_ok, out_valid_o && (out_item_o.event_res != EV_PHASE_OK), out_item_o.phase_value == 8'd0)
  `SPCP_ASSERT_IMP(a_phase_bound, out_valid_o && (out_item_o.event_res == EV_PHASE_OK), out_item_o.phase_value <= 8'(PHASE_MAX))

endmodule

bind serial_phase_command_parser_core spcp_checker u_spcp_checker (.*);
